>>> rtl/core/lepg_pkg.sv
// Shared types, constants and helpers for the LED effect pixel generator.
// No dependencies; compiled first.
package lepg_pkg;

   localparam int MAX_PIXELS_DEF  = 1024;
   localparam int SINE_DEPTH_DEF  = 1024;

   localparam int ELAPSED_W  = 32;
   localparam int PIXEL_W    = 10;
   localparam int PERIOD_W   = 16;
   localparam int COUNT_W    = 11;
   localparam int COLOR_W    = 24;
   localparam int CHAN_W     = 8;
   localparam int MODE_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int FRAC_W     = 16;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
   localparam logic [CHAN_W-1:0]   BRIGHT_RESET = 8'd255;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 11'd60;

   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
   localparam longint unsigned ONE_Q30    = 64'd1073741824;

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF, MODE_SOLID, MODE_PULSE, MODE_GRADIENT,
      MODE_STROBE, MODE_WAVE, MODE_RAINBOW, MODE_RANDOM
   } lepg_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE, CSR_PRIMARY, CSR_SECONDARY, CSR_PERIOD, CSR_BRIGHT, CSR_COUNT
   } lepg_csr_type;

   // divider pipeline payload
   typedef struct packed {
      logic [ELAPSED_W-1:0] e;
      logic [PERIOD_W-1:0]  rem;
      logic [PERIOD_W-1:0]  prem;
      logic [FRAC_W-1:0]    ph;
      logic [PIXEL_W-1:0]   px;
      logic [COUNT_W-1:0]   pos_rem;
      logic [FRAC_W-1:0]    pos_q;
      logic [COUNT_W-1:0]   r_rem;
      logic [FRAC_W:0]      r_q;
      logic                 r_big;
   } lepg_div_type;

   // x / 255 for x up to 16 bits
   function automatic logic [CHAN_W-1:0] lepg_div255(input logic [15:0] x);
      logic [31:0] m;
      m = 32'(x) * 32'd32897;
      return m[30:23];
   endfunction

   // sine table entry from a Q32 turn fraction f, as 0..255
   function automatic logic [CHAN_W-1:0] lepg_sine_val(input longint unsigned f);
      logic neg;
      longint unsigned x, t, t2, term, v, r;
      longint sum;
      neg  = (f >= 64'h8000_0000);
      x    = f & 64'h7FFF_FFFF;
      if (x > 64'h4000_0000) x = 64'h8000_0000 - x;
      t    = (x * TWO_PI_Q30) >> 32;
      t2   = (t * t) >> 30;
      term = t;
      sum  = longint'(t);
      term = ((term * t2) >> 30) / 64'd6;   sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd20;  sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 64'd42;  sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd72;  sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 64'd110; sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd156; sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 64'd210; sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd272; sum = sum + longint'(term);
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
      v = neg ? (ONE_Q30 - longint'(unsigned'(sum))) : (ONE_Q30 + longint'(unsigned'(sum)));
      r = (v * 64'd255 + 64'h4000_0000) >> 31;
      return r[CHAN_W-1:0];
   endfunction

endpackage

>>> rtl/core/lepg_req_if.sv
// Request channel: elapsed time and pixel index.
// Depends on lepg_pkg.
interface lepg_req_if;
   import lepg_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ELAPSED_W-1:0] elapsed_ms;
   logic [PIXEL_W-1:0]   pixel_index;
   modport source (output valid, elapsed_ms, pixel_index, input ready);
   modport sink   (input valid, elapsed_ms, pixel_index, output ready);
endinterface

>>> rtl/core/lepg_rsp_if.sv
// Response channel: pixel RGB.
// Depends on lepg_pkg.
interface lepg_rsp_if;
   import lepg_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> rtl/core/lepg_csr_if.sv
// Register write channel.
// Depends on lepg_pkg.
interface lepg_csr_if;
   import lepg_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/led_effect_pixel_generator.sv
// LED effect pixel generator top level: divider pipeline, sine table, color math.
// Depends on lepg_pkg and the lepg_req_if / lepg_rsp_if / lepg_csr_if interfaces.
//
//  channel  | dir | payload                       | handshake
//  ---------+-----+-------------------------------+-------------
//  req_if   | in  | elapsed_ms[32], pixel_index[10] | valid/ready
//  rsp_if   | out | red[8], green[8], blue[8]     | valid/ready
//  csr_if   | in  | index[3], data[24]            | valid/ready (ready always 1)
//
//  One request per cycle sustained while rsp_if does not stall; 48 restoring divider
//  steps, one bit each, then 6 color stages. The divider chain sets the depth.
//  Synchronous active-high reset clears the valid bits and loads register defaults.
//  A stall on rsp_if freezes the whole pipeline; req_if.ready drops with it.
//  Register writes reach the derived brightness colors through cprod_ff and then cb_ff.
module led_effect_pixel_generator #(
   parameter int MAX_PIXELS       = lepg_pkg::MAX_PIXELS_DEF,
   parameter int SINE_TABLE_DEPTH = lepg_pkg::SINE_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   lepg_req_if.sink   req_if,
   lepg_rsp_if.source rsp_if,
   lepg_csr_if.sink   csr_if
);
   import lepg_pkg::*;

   localparam int NA   = ELAPSED_W;        // elapsed mod period steps
   localparam int NB   = FRAC_W;           // phase fraction steps
   localparam int ND   = NA + NB;
   localparam int PX_STEPS = PIXEL_W + FRAC_W;
   localparam int SA_W = $clog2(SINE_TABLE_DEPTH);

   // ---------------- configuration registers ----------------
   lepg_mode_type         mode_ff;
   logic [COLOR_W-1:0]    pcol_ff, scol_ff;
   logic [PERIOD_W-1:0]   period_ff;
   logic [CHAN_W-1:0]     bri_ff;
   logic [COUNT_W-1:0]    count_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_OFF;
         pcol_ff   <= '0;
         scol_ff   <= '0;
         period_ff <= PERIOD_RESET;
         bri_ff    <= BRIGHT_RESET;
         count_ff  <= COUNT_RESET;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_MODE:      mode_ff   <= lepg_mode_type'(csr_if.data[MODE_W-1:0]);
            CSR_PRIMARY:   pcol_ff   <= csr_if.data[COLOR_W-1:0];
            CSR_SECONDARY: scol_ff   <= csr_if.data[COLOR_W-1:0];
            CSR_PERIOD:    period_ff <= csr_if.data[PERIOD_W-1:0];
            CSR_BRIGHT:    bri_ff    <= csr_if.data[CHAN_W-1:0];
            CSR_COUNT:     count_ff  <= csr_if.data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // derived settings: zero period -> 1, pixel count -> [1, MAX_PIXELS]
   logic [PERIOD_W-1:0] per_ff;
   logic [COUNT_W-1:0]  cnt_ff, cntm1_ff;
   logic [COUNT_W-1:0]  cnt_in;
   logic                multi_ff;

   always_comb begin
      cnt_in = count_ff;
      if (count_ff == '0) cnt_in = COUNT_W'(1);
      else if (17'(count_ff) > 17'(MAX_PIXELS)) cnt_in = COUNT_W'(MAX_PIXELS);
   end

   always_ff @(posedge clock) begin
      per_ff   <= (period_ff == '0) ? PERIOD_W'(1) : period_ff;
      cnt_ff   <= cnt_in;
      cntm1_ff <= cnt_in - COUNT_W'(1);
      multi_ff <= (cnt_in > COUNT_W'(1));
   end

   // brightness applied to both colors, per channel
   logic [15:0]       cprod_ff [6];
   logic [CHAN_W-1:0] cb_ff    [6];

   for (genvar c = 0; c < 6; c++) begin : g_cbright
      logic [CHAN_W-1:0] raw;
      if (c < 3) begin : g_p
         assign raw = pcol_ff[COLOR_W-1-CHAN_W*c -: CHAN_W];
      end else begin : g_s
         assign raw = scol_ff[COLOR_W-1-CHAN_W*(c-3) -: CHAN_W];
      end
      always_ff @(posedge clock) begin
         cprod_ff[c] <= 16'(raw) * 16'(bri_ff);
         cb_ff[c]    <= lepg_div255(cprod_ff[c]);
      end
   end

   // ---------------- pipeline control ----------------
   logic rsp_valid_ff;
   logic ce;
   assign ce           = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = ce;

   // ---------------- divider pipeline ----------------
   // stages 0..NA-1: elapsed mod period, one dividend bit each;
   // pixel position and gradient ratio run alongside in the first PX_STEPS.
   // stages NA..ND-1: (cyc << 16) / period, one quotient bit each.
   lepg_div_type div_ff [ND];
   logic         dv_ff  [ND];
   lepg_div_type div_head;

   always_comb begin
      div_head    = '0;
      div_head.e  = req_if.elapsed_ms;
      div_head.px = req_if.pixel_index;
   end

   for (genvar i = 0; i < ND; i++) begin : g_div
      lepg_div_type src, nxt;
      logic         src_v;
      logic         lane_bit;

      if (i == 0) begin : g_first
         assign src   = div_head;
         assign src_v = req_if.valid;
      end else begin : g_next
         assign src   = div_ff[i-1];
         assign src_v = dv_ff[i-1];
      end

      if (i < PIXEL_W) begin : g_lb
         assign lane_bit = src.px[PIXEL_W-1-i];
      end else begin : g_lz
         assign lane_bit = 1'b0;
      end

      if (i < NA) begin : g_mod
         logic [PERIOD_W:0]  t;
         logic [COUNT_W:0]   tp, tr;
         logic               gp, gr;
         always_comb begin
            nxt = src;
            t   = {src.rem, src.e[NA-1-i]};
            if (t >= {1'b0, per_ff}) nxt.rem = PERIOD_W'(t - {1'b0, per_ff});
            else                     nxt.rem = t[PERIOD_W-1:0];
            tp = {src.pos_rem, lane_bit};
            tr = {src.r_rem, lane_bit};
            gp = (tp >= {1'b0, cnt_ff});
            gr = (tr >= {1'b0, cntm1_ff});
            if (i < PX_STEPS) begin
               nxt.pos_rem = gp ? COUNT_W'(tp - {1'b0, cnt_ff}) : tp[COUNT_W-1:0];
               nxt.pos_q   = {src.pos_q[FRAC_W-2:0], gp};
               nxt.r_rem   = gr ? COUNT_W'(tr - {1'b0, cntm1_ff}) : tr[COUNT_W-1:0];
               nxt.r_q     = {src.r_q[FRAC_W-1:0], gr};
               nxt.r_big   = src.r_big | src.r_q[FRAC_W];
            end
         end
      end else begin : g_frac
         logic [PERIOD_W-1:0] pr;
         logic [PERIOD_W:0]   t;
         logic                ge;
         if (i == NA) begin : g_start
            assign pr = src.rem;
         end else begin : g_cont
            assign pr = src.prem;
         end
         always_comb begin
            nxt = src;
            t   = {pr, 1'b0};
            ge  = (t >= {1'b0, per_ff});
            nxt.prem = ge ? PERIOD_W'(t - {1'b0, per_ff}) : t[PERIOD_W-1:0];
            nxt.ph   = {src.ph[FRAC_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset)   dv_ff[i] <= 1'b0;
         else if (ce) dv_ff[i] <= src_v;
         if (ce) div_ff[i] <= nxt;
      end
   end

   lepg_div_type dq;
   logic         dq_v;
   assign dq   = div_ff[ND-1];
   assign dq_v = dv_ff[ND-1];

   // ---------------- sine table ----------------
   logic [CHAN_W-1:0] sine_lut [SINE_TABLE_DEPTH];
   for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_lut
      localparam longint unsigned F = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
      assign sine_lut[k] = lepg_sine_val(F);
   end

   // ---------------- T0: phases, strobe, rainbow, gradient blend ----------------
   logic [FRAC_W:0]   r_val;
   logic [FRAC_W-1:0] hue, sph;
   logic [18:0]       h6;
   logic [15:0]       rrem;
   logic [23:0]       up_p;
   logic [24:0]       dn_p;
   logic [CHAN_W-1:0] up, dn;
   logic [CHAN_W-1:0] rb [3];
   logic [CHAN_W-1:0] gb [3];

   logic [SA_W-1:0]   t0_addr_ff;
   logic              t0_on_ff, t0_v_ff;
   logic [CHAN_W-1:0] t0_rb_ff [3];
   logic [CHAN_W-1:0] t0_g_ff  [3];

   always_comb begin
      if (!multi_ff)                                  r_val = '0;
      else if (dq.r_big || dq.r_q > 17'h10000)        r_val = 17'h10000;
      else                                            r_val = dq.r_q;
      hue  = dq.pos_q + dq.ph;
      sph  = (mode_ff == MODE_WAVE) ? hue : dq.ph;
      h6   = 19'(hue) * 19'd6;
      rrem = h6[15:0];
      up_p = 24'(rrem) * 24'd255;
      dn_p = 25'(17'h10000 - 17'(rrem)) * 25'd255;
      up   = up_p[23:16];
      dn   = dn_p[23:16];
      rb[0] = '0; rb[1] = '0; rb[2] = '0;
      case (h6[18:16])
         3'd0:    begin rb[0] = 8'd255; rb[1] = up;     end
         3'd1:    begin rb[0] = dn;     rb[1] = 8'd255; end
         3'd2:    begin rb[1] = 8'd255; rb[2] = up;     end
         3'd3:    begin rb[1] = dn;     rb[2] = 8'd255; end
         3'd4:    begin rb[0] = up;     rb[2] = 8'd255; end
         default: begin rb[0] = 8'd255; rb[2] = dn;     end
      endcase
   end

   for (genvar c = 0; c < 3; c++) begin : g_grad
      logic signed [8:0]  d;
      logic signed [27:0] gs;
      always_comb begin
         d     = $signed({1'b0, cb_ff[c+3]}) - $signed({1'b0, cb_ff[c]});
         gs    = $signed({4'b0, cb_ff[c], 16'b0}) + 28'(d * $signed({1'b0, r_val}));
         gb[c] = gs[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)   t0_v_ff <= 1'b0;
      else if (ce) t0_v_ff <= dq_v;
      if (ce) begin
         t0_addr_ff <= SA_W'((32'(sph) * 32'(SINE_TABLE_DEPTH)) >> FRAC_W);
         t0_on_ff   <= (dq.rem < (per_ff >> 1));
         t0_rb_ff   <= rb;
         t0_g_ff    <= gb;
      end
   end

   // ---------------- T1: sine read ----------------
   logic [CHAN_W-1:0] t1_s_ff;
   logic              t1_on_ff, t1_v_ff;
   logic [CHAN_W-1:0] t1_rb_ff [3];
   logic [CHAN_W-1:0] t1_g_ff  [3];

   always_ff @(posedge clock) begin
      if (reset)   t1_v_ff <= 1'b0;
      else if (ce) t1_v_ff <= t0_v_ff;
      if (ce) begin
         t1_s_ff  <= sine_lut[t0_addr_ff];
         t1_on_ff <= t0_on_ff;
         t1_rb_ff <= t0_rb_ff;
         t1_g_ff  <= t0_g_ff;
      end
   end

   // ---------------- T2: sine products ----------------
   logic [15:0]       t2_m_ff  [3];
   logic [CHAN_W-1:0] t2_rb_ff [3];
   logic              t2_on_ff, t2_v_ff;

   for (genvar c = 0; c < 3; c++) begin : g_t2
      logic [15:0] m;
      always_comb begin
         case (mode_ff)
            MODE_GRADIENT: m = 16'(t1_g_ff[c]) * 16'(t1_s_ff);
            // wave blend: c1*(255-s) + c2*s, never negative
            MODE_WAVE:     m = 16'(cb_ff[c]) * 16'(8'd255 - t1_s_ff)
                             + 16'(cb_ff[c+3]) * 16'(t1_s_ff);
            default:       m = 16'(cb_ff[c]) * 16'(t1_s_ff);
         endcase
      end
      always_ff @(posedge clock) if (ce) t2_m_ff[c] <= m;
   end

   always_ff @(posedge clock) begin
      if (reset)   t2_v_ff <= 1'b0;
      else if (ce) t2_v_ff <= t1_v_ff;
      if (ce) begin
         t2_rb_ff <= t1_rb_ff;
         t2_on_ff <= t1_on_ff;
      end
   end

   // ---------------- T3: /255 and mode select ----------------
   logic [CHAN_W-1:0] t3_v_ff [3];
   logic              t3_ok_ff;
   logic              need_b;

   assign need_b = (mode_ff == MODE_PULSE) || (mode_ff == MODE_GRADIENT)
                || (mode_ff == MODE_RAINBOW);

   for (genvar c = 0; c < 3; c++) begin : g_t3
      logic [CHAN_W-1:0] v;
      always_comb begin
         case (mode_ff)
            MODE_SOLID:    v = cb_ff[c];
            MODE_PULSE,
            MODE_GRADIENT,
            MODE_WAVE:     v = lepg_div255(t2_m_ff[c]);
            MODE_STROBE:   v = t2_on_ff ? cb_ff[c] : '0;
            MODE_RAINBOW:  v = t2_rb_ff[c];
            default:       v = '0;
         endcase
      end
      always_ff @(posedge clock) if (ce) t3_v_ff[c] <= v;
   end

   always_ff @(posedge clock) begin
      if (reset)   t3_ok_ff <= 1'b0;
      else if (ce) t3_ok_ff <= t2_v_ff;
   end

   // ---------------- T4: brightness product ----------------
   logic [15:0] t4_m_ff [3];
   logic        t4_v_ff;

   for (genvar c = 0; c < 3; c++) begin : g_t4
      always_ff @(posedge clock)
         if (ce) t4_m_ff[c] <= need_b ? 16'(t3_v_ff[c]) * 16'(bri_ff) : 16'(t3_v_ff[c]);
   end

   always_ff @(posedge clock) begin
      if (reset)   t4_v_ff <= 1'b0;
      else if (ce) t4_v_ff <= t3_ok_ff;
   end

   // ---------------- output register ----------------
   logic [CHAN_W-1:0] out_ff [3];

   for (genvar c = 0; c < 3; c++) begin : g_out
      always_ff @(posedge clock)
         if (ce) out_ff[c] <= need_b ? lepg_div255(t4_m_ff[c]) : t4_m_ff[c][CHAN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset)   rsp_valid_ff <= 1'b0;
      else if (ce) rsp_valid_ff <= t4_v_ff;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.red   = out_ff[0];
   assign rsp_if.green = out_ff[1];
   assign rsp_if.blue  = out_ff[2];

endmodule

>>> tb/lepg_checker.sv
`timescale 1ns / 100ps
// Pixel color predictor and response scoreboard for led_effect_pixel_generator.
// Depends on lepg_pkg and the lepg_req_if / lepg_rsp_if / lepg_csr_if interfaces.
module lepg_checker (
   input  logic clock,
   input  logic reset,
   lepg_req_if  req_mon,
   lepg_rsp_if  rsp_mon,
   lepg_csr_if  csr_mon,
   output int   fail_count,
   output int   pending,
   output int   pixels_checked
);
   import lepg_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_rgb_t;

   pixel_rgb_t         rgb_queue[$];
   logic [CHAN_W-1:0]  sine_lut[SINE_DEPTH_DEF];

   lepg_mode_type      mode_q;
   logic [COLOR_W-1:0] color_a, color_b;
   logic [PERIOD_W-1:0] period_q;
   logic [CHAN_W-1:0]  bright_q;
   logic [COUNT_W-1:0] count_q;

   // half-offset sine, Q30 Taylor series on the angle folded into a quarter turn
   function automatic logic [CHAN_W-1:0] sine_entry(input int unsigned k);
      longint unsigned f, x, t, t2, term, v;
      longint          sum;
      bit              neg;
      f   = (longint'(k) << 32) / SINE_DEPTH_DEF;
      neg = f >= 64'h8000_0000;
      x   = f & 64'h7FFF_FFFF;
      if (x > 64'h4000_0000) x = 64'h8000_0000 - x;
      t    = (x * TWO_PI_Q30) >> 32;
      t2   = (t * t) >> 30;
      term = t;
      sum  = t;
      for (int n = 1; n <= 8; n++) begin
         term = ((term * t2) >> 30) / ((2 * n) * (2 * n + 1));
         if (n % 2) sum -= term;
         else sum += term;
      end
      if (sum < 0) sum = 0;
      if (sum > ONE_Q30) sum = ONE_Q30;
      v = neg ? ONE_Q30 - sum : ONE_Q30 + sum;
      return 8'((v * 255 + 64'h4000_0000) >> 31);
   endfunction

   function automatic int unsigned sine_of(input int unsigned phase);
      return sine_lut[((phase & 16'hFFFF) * SINE_DEPTH_DEF) >> 16];
   endfunction

   function automatic int unsigned scale(input int unsigned v);
      return ((v & 8'hFF) * bright_q) / 255;
   endfunction

   function automatic int unsigned chan_of(input logic [COLOR_W-1:0] c, input int ch);
      return scale((c >> (16 - 8 * ch)) & 8'hFF);
   endfunction

   function automatic pixel_rgb_t pixel_color(input logic [ELAPSED_W-1:0] e,
                                               input logic [PIXEL_W-1:0] px);
      int unsigned p, cnt, cyc, ph, pos, s, hue, h6, rem, up, dn;
      int unsigned lvl[3];
      longint      ratio, c1, c2, num;
      pixel_rgb_t  res;
      p   = (period_q == 0) ? 1 : period_q;
      cnt = (count_q == 0) ? 1 : count_q;
      if (cnt > MAX_PIXELS_DEF) cnt = MAX_PIXELS_DEF;
      cyc = e % p;
      ph  = (cyc << 16) / p;
      pos = (int'(px) << 16) / cnt;
      lvl = '{0, 0, 0};
      case (mode_q)
         MODE_SOLID: for (int ch = 0; ch < 3; ch++) lvl[ch] = chan_of(color_a, ch);
         MODE_PULSE: begin
            s = sine_of(ph);
            for (int ch = 0; ch < 3; ch++) lvl[ch] = scale(chan_of(color_a, ch) * s / 255);
         end
         MODE_GRADIENT: begin
            s = sine_of(ph);
            ratio = 0;
            if (cnt > 1) begin
               ratio = (longint'(px) << 16) / (cnt - 1);
               if (ratio > 65536) ratio = 65536;
            end
            for (int ch = 0; ch < 3; ch++) begin
               c1  = chan_of(color_a, ch);
               c2  = chan_of(color_b, ch);
               num = c1 * 65536 + (c2 - c1) * ratio;
               lvl[ch] = scale(int'(num >>> 16) * s / 255);
            end
         end
         MODE_STROBE:
            if (cyc < p / 2)
               for (int ch = 0; ch < 3; ch++) lvl[ch] = chan_of(color_a, ch);
         MODE_WAVE: begin
            s = sine_of(pos + ph);
            for (int ch = 0; ch < 3; ch++) begin
               c1  = chan_of(color_a, ch);
               c2  = chan_of(color_b, ch);
               lvl[ch] = int'((c1 * 255 + (c2 - c1) * s) / 255);
            end
         end
         MODE_RAINBOW: begin
            hue = (pos + ph) & 16'hFFFF;
            h6  = hue * 6;
            rem = h6 & 16'hFFFF;
            up  = (rem * 255) >> 16;
            dn  = ((65536 - rem) * 255) >> 16;
            case (h6 >> 16)
               0: lvl = '{255, up, 0};
               1: lvl = '{dn, 255, 0};
               2: lvl = '{0, 255, up};
               3: lvl = '{0, dn, 255};
               4: lvl = '{up, 0, 255};
               default: lvl = '{255, 0, dn};
            endcase
            for (int ch = 0; ch < 3; ch++) lvl[ch] = scale(lvl[ch]);
         end
         default: ;
      endcase
      res.red   = lvl[0][7:0];
      res.green = lvl[1][7:0];
      res.blue  = lvl[2][7:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      for (int k = 0; k < SINE_DEPTH_DEF; k++) sine_lut[k] = sine_entry(k);
   end

   assign pending = rgb_queue.size();

   always @(posedge clock) begin
      pixel_rgb_t want;
      if (reset) begin
         mode_q   <= MODE_OFF;
         color_a  <= '0;
         color_b  <= '0;
         period_q <= PERIOD_RESET;
         bright_q <= BRIGHT_RESET;
         count_q  <= COUNT_RESET;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (lepg_csr_type'(csr_mon.index))
               CSR_MODE:      mode_q   <= lepg_mode_type'(csr_mon.data[MODE_W-1:0]);
               CSR_PRIMARY:   color_a  <= csr_mon.data;
               CSR_SECONDARY: color_b  <= csr_mon.data;
               CSR_PERIOD:    period_q <= csr_mon.data[PERIOD_W-1:0];
               CSR_BRIGHT:    bright_q <= csr_mon.data[CHAN_W-1:0];
               CSR_COUNT:     count_q  <= csr_mon.data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            rgb_queue.push_back(pixel_color(req_mon.elapsed_ms, req_mon.pixel_index));
         if (rsp_mon.valid && rsp_mon.ready) begin
            pixels_checked++;
            if (rgb_queue.size() == 0) begin
               report_mismatch("unexpected response", rsp_mon.red, -1);
            end else begin
               want = rgb_queue.pop_front();
               if (rsp_mon.red !== want.red) report_mismatch("red", rsp_mon.red, want.red);
               if (rsp_mon.green !== want.green)
                  report_mismatch("green", rsp_mon.green, want.green);
               if (rsp_mon.blue !== want.blue) report_mismatch("blue", rsp_mon.blue, want.blue);
            end
         end
      end
   end

   initial begin
      fail_count     = 0;
      pixels_checked = 0;
   end
endmodule

>>> tb/tb_led_effect_pixel_generator.sv
`timescale 1ns / 100ps
// Stimulus and verdict for led_effect_pixel_generator; checking lives in lepg_checker.
// Depends on lepg_pkg, the three channel interfaces and the block itself.
module tb_led_effect_pixel_generator;
   import lepg_pkg::*;

   // write latency plus margin before touching registers or ending the run
   localparam int DRAIN_CYCLES = 70;
   localparam lepg_csr_type CSR_SPARE = lepg_csr_type'(3'd6);
   localparam lepg_csr_type CSR_SPARE_HI = lepg_csr_type'(3'd7);

   logic clock;
   logic reset;
   int   fail_count, pending, pixels_checked;
   int   burst_left;
   int   cycle_no;
   int   phase_count;

   lepg_req_if req_if ();
   lepg_rsp_if rsp_if ();
   lepg_csr_if csr_if ();

   led_effect_pixel_generator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   lepg_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_mon        (csr_if),
      .fail_count     (fail_count),
      .pending        (pending),
      .pixels_checked (pixels_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver backpressure: the stall density steps in turn, driven by cycle_no, through
   // always-ready, light, heavy and an alternating pattern.
   always @(negedge clock) begin
      cycle_no <= cycle_no + 1;
      case ((cycle_no / 200) % 4)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= ($urandom_range(3) != 0);
         2: rsp_if.ready <= ($urandom_range(3) == 0);
         default: rsp_if.ready <= cycle_no[1];
      endcase
   end

   // One register write; the port is only used while the pipeline is drained.
   task automatic write_reg(input lepg_csr_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // One pixel request. Bursts of random length, random gaps in between;
   // valid stays high across back-to-back requests in a burst.
   task automatic send_pixel(input logic [ELAPSED_W-1:0] e, input logic [PIXEL_W-1:0] px);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(4);
         @(negedge clock);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(1, 12);
      end else begin
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.elapsed_ms  <= e;
      req_if.pixel_index <= px;
      do @(posedge clock); while (!req_if.ready);
      burst_left--;
   endtask

   // Stop requesting and let every expected pixel come back, then settle.
   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_all(input lepg_mode_type m, input logic [23:0] a, input logic [23:0] b,
                          input logic [15:0] per, input logic [7:0] br, input logic [10:0] cnt);
      drain();
      write_reg(CSR_MODE, {21'($urandom), 3'(m)});
      write_reg(CSR_PRIMARY, a);
      write_reg(CSR_SECONDARY, b);
      write_reg(CSR_PERIOD, {8'($urandom), per});
      write_reg(CSR_BRIGHT, {16'($urandom), br});
      write_reg(CSR_COUNT, {13'($urandom), cnt});
      phase_count++;
   endtask

   function automatic logic [15:0] pick_period();
      case ($urandom_range(7))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'd2;
         3: return 16'hFFFF;
         4: return 16'($urandom_range(3, 100));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [10:0] pick_count();
      case ($urandom_range(7))
         0: return 11'd0;
         1: return 11'd1;
         2: return 11'd2;
         3: return 11'd1024;
         4: return 11'h7FF;
         5: return 11'($urandom_range(1025, 2047));
         default: return 11'($urandom_range(3, 1023));
      endcase
   endfunction

   function automatic logic [7:0] pick_bright();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_elapsed();
      case ($urandom_range(3))
         0: return $urandom_range(0, 5000);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 100);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      lepg_mode_type m;
      cycle_no         = 0;
      burst_left       = 0;
      phase_count      = 0;
      reset            = 1'b1;
      req_if.valid       = 1'b0;
      req_if.elapsed_ms  = '0;
      req_if.pixel_index = '0;
      rsp_if.ready       = 1'b1;
      csr_if.valid       = 1'b0;
      csr_if.index       = CSR_MODE;
      csr_if.data        = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset defaults: mode off, so black regardless of input.
      send_pixel(32'd0, 10'd0);
      send_pixel(32'hFFFF_FFFF, 10'h3FF);

      // Directed: each mode at full-scale colors and field extremes.
      for (int k = 0; k < 8; k++) begin
         m = lepg_mode_type'(k);
         set_all(m, 24'hFFFFFF, 24'h000000, 16'd1000, 8'd255, 11'd60);
         send_pixel(32'd0, 10'd0);
         send_pixel(32'd250, 10'd59);
         send_pixel(32'hFFFF_FFFF, 10'h3FF);
      end
      // zero period (strobe stays black), zero pixel count, oversized count,
      // pixel beyond the strip, and spare register indexes that must be ignored
      set_all(MODE_STROBE, 24'hA5C35A, 24'h5A3CA5, 16'd0, 8'd128, 11'd0);
      write_reg(CSR_SPARE, 24'hFFFFFF);
      write_reg(CSR_SPARE_HI, 24'hFFFFFF);
      send_pixel(32'd7, 10'd3);
      set_all(MODE_GRADIENT, 24'hFF0000, 24'h00FF00, 16'd1, 8'd200, 11'd2047);
      send_pixel(32'd0, 10'h3FF);
      set_all(MODE_WAVE, 24'h0000FF, 24'hFF00FF, 16'hFFFF, 8'd0, 11'd1);
      send_pixel(32'd123, 10'd700);
      set_all(MODE_RAINBOW, 24'h0, 24'h0, 16'd6, 8'd255, 11'd10);
      send_pixel(32'd5, 10'd999);

      // Random phases: new register settings, then a run of pixel requests.
      // Between phases the sender holds off until the pipeline is empty.
      for (int ph = 0; ph < 40; ph++) begin
         set_all(lepg_mode_type'($urandom_range(7)), 24'($urandom), 24'($urandom),
                 pick_period(), pick_bright(), pick_count());
         repeat (45) send_pixel(pick_elapsed(), 10'($urandom));
      end

      drain();
      $display("Checked %0d pixels over %0d register settings, all modes,", pixels_checked,
               phase_count);
      $display("with random request gaps and response stalls.");
      if (fail_count == 0)
         $display("** led_effect_pixel_generator: PASSED **");
      else
         $display("** led_effect_pixel_generator: FAILED **");
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout with %0d responses outstanding", pending);
      $display("** led_effect_pixel_generator: FAILED **");
      $finish;
   end
endmodule

>>> filelist.f
rtl/core/lepg_pkg.sv
rtl/core/lepg_req_if.sv
rtl/core/lepg_rsp_if.sv
rtl/core/lepg_csr_if.sv
rtl/core/led_effect_pixel_generator.sv
tb/lepg_checker.sv
tb/tb_led_effect_pixel_generator.sv
